>>> rtl/grd_pkg.sv
// Shared types and constants for the grid ray caster.
package grd_pkg;

  localparam int MAP_SIDE_DEF  = 64;
  localparam int TEX_COLS_DEF  = 64;
  localparam int MAX_STEPS_DEF = 128;

  localparam logic [23:0] PERP_MAX = 24'hFFFFFF;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_CAST  = 1'b1;

  // One item as it travels from the front part to the back part.
  typedef struct packed {
    logic        mode;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic [7:0]  tile_value;
    logic        door_present;
    logic        door_opens_up;
    logic [8:0]  door_progress;
    logic [7:0]  door_texture;
    logic [21:0] start_x;
    logic [21:0] start_y;
    logic [16:0] dir_x;
    logic [16:0] dir_y;
  } grd_item_t;

  typedef struct packed {
    logic [5:0]  hit_x;
    logic [5:0]  hit_y;
    logic        side;
    logic [23:0] perp_dist;
    logic [15:0] wall_frac;
    logic [5:0]  tex_column;
    logic [7:0]  hit_tile;
    logic [7:0]  texture_index;
    logic        is_door;
    logic        hit_opens_up;
    logic [8:0]  hit_progress;
    logic        escaped;
  } grd_res_t;

endpackage

>>> rtl/grd_fifo.sv
// Two-entry queue between the front part and the ray engine.
module grd_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  grd_pkg::grd_item_t wr_data,
  output logic               rd_valid,
  input  logic               rd_ready,
  output grd_pkg::grd_item_t rd_data
);
  import grd_pkg::*;

  grd_item_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= ~wp_r;
      if (rd_valid && rd_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
    end
  end
endmodule

>>> rtl/grd_div.sv
// Restoring divider, one quotient bit per cycle, 48 by 24 bits.
module grd_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [23:0] divisor,
  output logic        done,
  output logic [47:0] quot
);
  logic [47:0] q_r;
  logic [24:0] rem_r;
  logic [23:0] d_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [24:0] sh;
  logic [25:0] diff;

  assign sh   = {rem_r[23:0], q_r[47]};
  assign diff = {1'b0, sh} - {2'b0, d_r};
  assign quot = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= dividend;
        rem_r  <= '0;
        d_r    <= divisor;
      end else if (busy_r) begin
        if (!diff[25]) begin
          rem_r <= diff[24:0];
          q_r   <= {q_r[46:0], 1'b1};
        end else begin
          rem_r <= sh;
          q_r   <= {q_r[46:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd47) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule

>>> rtl/grd_front.sv
// Front part: accepts items, drops out-of-map writes, feeds the queue.
module grd_front #(
  parameter int MAP_SIDE = grd_pkg::MAP_SIDE_DEF
) (
  input  logic               in_valid,
  output logic               in_ready,
  input  grd_pkg::grd_item_t in_item,
  output logic               q_valid,
  input  logic               q_ready,
  output grd_pkg::grd_item_t q_item
);
  import grd_pkg::*;

  logic in_map;

  assign in_map = ({26'd0, in_item.cell_x} < MAP_SIDE) &&
                  ({26'd0, in_item.cell_y} < MAP_SIDE);

  // Writes outside the map are consumed here and never queued.
  assign in_ready = q_ready || ((in_item.mode == MODE_WRITE) && !in_map);
  assign q_valid  = in_valid && ((in_item.mode == MODE_CAST) || in_map);
  assign q_item   = in_item;
endmodule

>>> rtl/grd_engine.sv
// Back part: map memory, DDA walk and hit evaluation.
module grd_engine #(
  parameter int MAP_SIDE  = grd_pkg::MAP_SIDE_DEF,
  parameter int TEX_COLS  = grd_pkg::TEX_COLS_DEF,
  parameter int MAX_STEPS = grd_pkg::MAX_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  grd_pkg::grd_item_t q_item,
  output logic               res_valid,
  input  logic               res_ready,
  output grd_pkg::grd_res_t  res
);
  import grd_pkg::*;

  localparam int CW    = $clog2(MAP_SIDE);
  localparam int AW    = 2 * CW;
  localparam int CELLS = MAP_SIDE * MAP_SIDE;
  localparam int SW    = $clog2(MAX_STEPS + 1);
  localparam int TW    = $clog2(TEX_COLS);

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_DDX   = 13'b0000000000100,
    S_DDY   = 13'b0000000001000,
    S_SIDE  = 13'b0000000010000,
    S_STEP  = 13'b0000000100000,
    S_READ  = 13'b0000001000000,
    S_TEST  = 13'b0000010000000,
    S_PERP  = 13'b0000100000000,
    S_WALL  = 13'b0001000000000,
    S_WADD  = 13'b0010000000000,
    S_DONE  = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } st_t;

  st_t st_r, st_nxt;

  // Map memory: tile plus door record per cell.
  logic [26:0] map_mem [CELLS];
  logic [26:0] rd_q_r;
  logic        we;
  logic [AW-1:0] wa, ra;
  logic [26:0] wd;
  logic [AW-1:0] clr_r;

  always_ff @(posedge clk) begin
    if (we) map_mem[wa] <= wd;
    rd_q_r <= map_mem[ra];
  end

  grd_item_t it_r;
  logic signed [8:0] mx_r, my_r;
  logic [47:0] ddx_r, ddy_r;
  logic [63:0] sdx_r, sdy_r;
  logic        side_r, hit_r;
  logic [SW-1:0] n_r;
  logic [23:0] perp_r;
  logic signed [39:0] prod_r;
  logic signed [40:0] num_r;
  logic [15:0] frac_r;
  grd_res_t    res_r, res_nxt;

  logic signed [16:0] dx, dy;
  logic [16:0] adx, ady;
  logic [15:0] fx, fy;
  assign dx  = it_r.dir_x;
  assign dy  = it_r.dir_y;
  assign adx = dx[16] ? -dx : dx;
  assign ady = dy[16] ? -dy : dy;
  assign fx  = it_r.start_x[15:0];
  assign fy  = it_r.start_y[15:0];

  // Shared divider.
  logic        dv_start, dv_done;
  logic [47:0] dv_a, dv_q;
  logic [23:0] dv_b;
  grd_div u_div (.clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a),
                 .divisor(dv_b), .done(dv_done), .quot(dv_q));
  logic dv_go_r;

  logic takex;
  assign takex = (dy == '0) || ((dx != '0) && (sdx_r < sdy_r));

  logic signed [8:0] nmx, nmy;
  assign nmx = takex ? (dx[16] ? mx_r - 9'sd1 : mx_r + 9'sd1) : mx_r;
  assign nmy = takex ? my_r : (dy[16] ? my_r - 9'sd1 : my_r + 9'sd1);
  logic out_map;
  assign out_map = nmx[8] || nmy[8] || (nmx >= MAP_SIDE) || (nmy >= MAP_SIDE);

  // Distance to the crossed boundary, Q16, signed.
  logic signed [40:0] num_c;
  logic signed [8:0]  bnd;
  assign bnd   = !side_r ? (dx[16] ? mx_r + 9'sd1 : mx_r)
                         : (dy[16] ? my_r + 9'sd1 : my_r);
  assign num_c = ($signed({{16{bnd[8]}}, bnd, 16'd0}))
               - $signed({19'd0, (side_r ? it_r.start_y : it_r.start_x)});
  logic [40:0] anum;
  assign anum = num_r[40] ? -num_r : num_r;

  logic signed [16:0] dmain, doth;
  assign dmain = side_r ? dy : dx;
  assign doth  = side_r ? dx : dy;
  logic [16:0] admain;
  assign admain = side_r ? ady : adx;

  // A negative wall quotient rounds toward minus infinity: the magnitude is
  // divided with the divisor minus one added, which gives the ceiling.
  logic        neg_q;
  logic [39:0] aprod;
  assign aprod = prod_r[39] ? -prod_r : prod_r;
  assign neg_q = prod_r[39] ^ dmain[16];
  logic signed [40:0] wq;
  logic [15:0] wall_lo;
  assign wq = neg_q ? -$signed({1'b0, dv_q[39:0]}) : $signed({1'b0, dv_q[39:0]});

  logic [TW+15:0] colp;
  logic [TW-1:0]  col;
  logic mirror;
  assign colp   = {{TW{1'b0}}, frac_r} * TEX_COLS[TW:0];
  assign mirror = (!side_r && !dx[16] && dx != '0) || (side_r && dy[16]);
  assign col    = mirror ? TW'(TEX_COLS - 1) - colp[TW+15:16] : colp[TW+15:16];

  logic [7:0]  t_tile;
  logic [18:0] t_door;
  assign t_tile = rd_q_r[7:0];
  assign t_door = rd_q_r[26:8];

  assign q_ready   = (st_r == S_IDLE);
  assign res_valid = (st_r == S_OUT);
  assign res       = res_r;

  always_comb begin
    we = 1'b0; wa = '0; wd = '0;
    ra = AW'(my_r[CW-1:0] * MAP_SIDE) + AW'(mx_r[CW-1:0]);
    if (st_r == S_CLEAR) begin
      we = 1'b1; wa = clr_r;
    end else if (st_r == S_IDLE && q_valid && q_item.mode == MODE_WRITE) begin
      we = 1'b1;
      wa = AW'(q_item.cell_y[CW-1:0] * MAP_SIDE) + AW'(q_item.cell_x[CW-1:0]);
      wd = {q_item.door_texture, q_item.door_progress, q_item.door_opens_up,
            q_item.door_present, q_item.tile_value};
    end
  end

  always_comb begin
    st_nxt   = st_r;
    dv_start = 1'b0;
    dv_a     = '0;
    dv_b     = '0;
    case (st_r)
      S_CLEAR: if (clr_r == AW'(CELLS - 1)) st_nxt = S_IDLE;
      S_IDLE:  if (q_valid && q_item.mode == MODE_CAST) st_nxt = S_DDX;
      S_DDX: begin
        dv_a = 48'd1 << 30; dv_b = {7'd0, adx};
        if (dx == '0) st_nxt = S_DDY;
        else begin
          dv_start = !dv_go_r;
          if (dv_done) st_nxt = S_DDY;
        end
      end
      S_DDY: begin
        dv_a = 48'd1 << 30; dv_b = {7'd0, ady};
        if (dy == '0) st_nxt = S_SIDE;
        else begin
          dv_start = !dv_go_r;
          if (dv_done) st_nxt = S_SIDE;
        end
      end
      S_SIDE: st_nxt = (dx == '0 && dy == '0) ? S_DONE : S_STEP;
      S_STEP: st_nxt = (out_map || n_r == SW'(MAX_STEPS)) ? S_DONE : S_READ;
      S_READ: st_nxt = S_TEST;
      S_TEST: begin
        if (t_tile != 8'd0 && !(t_door[0] && t_door[10:2] >= 9'd256)) st_nxt = S_PERP;
        else if (n_r == SW'(MAX_STEPS)) st_nxt = S_DONE;
        else st_nxt = S_STEP;
      end
      S_PERP: begin
        dv_a = {anum[33:0], 14'd0}; dv_b = {7'd0, admain};
        dv_start = !dv_go_r;
        if (dv_done) st_nxt = S_WALL;
      end
      S_WALL: begin
        dv_a = neg_q ? {8'd0, aprod} + {31'd0, admain} - 48'd1 : {8'd0, aprod};
        dv_b = {7'd0, admain};
        dv_start = !dv_go_r;
        if (dv_done) st_nxt = S_WADD;
      end
      S_WADD: st_nxt = S_DONE;
      S_DONE: st_nxt = S_OUT;
      S_OUT:  if (res_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  assign wall_lo = 16'(wq) + (side_r ? fx : fy);

  always_comb begin
    res_nxt      = '0;
    res_nxt.side = side_r;
    if (!hit_r) begin
      res_nxt.perp_dist = PERP_MAX;
      res_nxt.escaped   = 1'b1;
    end else begin
      res_nxt.hit_x         = 6'(mx_r);
      res_nxt.hit_y         = 6'(my_r);
      res_nxt.perp_dist     = perp_r;
      res_nxt.wall_frac     = frac_r;
      res_nxt.tex_column    = 6'(col);
      res_nxt.hit_tile      = t_tile;
      res_nxt.is_door       = t_door[0];
      res_nxt.texture_index = t_door[0] ? t_door[18:11] : t_tile - 8'd1;
      res_nxt.hit_opens_up  = t_door[0] & t_door[1];
      res_nxt.hit_progress  = t_door[0] ? t_door[10:2] : 9'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_CLEAR;
      clr_r   <= '0;
      dv_go_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_CLEAR) clr_r <= clr_r + AW'(1);
      if (dv_start) dv_go_r <= 1'b1;
      else if (dv_done) dv_go_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        it_r   <= q_item;
        mx_r   <= {3'd0, q_item.start_x[21:16]};
        my_r   <= {3'd0, q_item.start_y[21:16]};
        ddx_r  <= '0; ddy_r <= '0;
        side_r <= 1'b0; hit_r <= 1'b0;
        n_r    <= '0;
      end
      S_DDX: if (dv_done) ddx_r <= dv_q;
      S_DDY: if (dv_done) ddy_r <= dv_q;
      S_SIDE: begin
        sdx_r <= (dx == '0) ? 64'd0 :
                 64'((dx[16] ? {1'b0, fx} : 17'd65536 - {1'b0, fx}) * ddx_r[31:0]);
        sdy_r <= (dy == '0) ? 64'd0 :
                 64'((dy[16] ? {1'b0, fy} : 17'd65536 - {1'b0, fy}) * ddy_r[31:0]);
      end
      S_STEP: if (n_r != SW'(MAX_STEPS)) begin
        if (takex) sdx_r <= sdx_r + {ddx_r, 16'd0};
        else       sdy_r <= sdy_r + {ddy_r, 16'd0};
        side_r <= !takex;
        mx_r <= nmx; my_r <= nmy;
        n_r  <= n_r + SW'(1);
      end
      S_TEST: if (st_nxt == S_PERP) begin
        hit_r <= 1'b1;
        num_r <= num_c;
      end
      S_PERP: begin
        prod_r <= 40'(num_r * doth);
        if (dv_done) perp_r <= (dv_q > {24'd0, PERP_MAX}) ? PERP_MAX : dv_q[23:0];
      end
      S_WADD: frac_r <= wall_lo;
      S_WALL: if (dv_done) frac_r <= 16'(wq);
      S_DONE: res_r <= res_nxt;
      default: ;
    endcase
  end
endmodule

>>> rtl/grid_ray_dda_wall_hit_top.sv
// Top level of the grid ray caster: front part, queue and ray engine.
//   channel | direction | transfer when
//   in_*    | input     | in_valid && in_ready
//   out_*   | output    | out_valid && out_ready
// A write is done by the engine in its idle state; a cast uses the divider
// up to four times and walks the step, read and test states per grid step.
// After reset the engine clears all MAP_SIDE*MAP_SIDE cells, one cell a cycle,
// before it takes items. A stalled result holds the engine; the queue keeps
// taking up to two items and the front part still drops out-of-map writes.
module grid_ray_dda_wall_hit_top #(
  parameter int MAP_SIDE  = grd_pkg::MAP_SIDE_DEF,
  parameter int TEX_COLS  = grd_pkg::TEX_COLS_DEF,
  parameter int MAX_STEPS = grd_pkg::MAX_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [5:0]  in_cell_x,
  input  logic [5:0]  in_cell_y,
  input  logic [7:0]  in_tile_value,
  input  logic        in_door_present,
  input  logic        in_door_opens_up,
  input  logic [8:0]  in_door_progress,
  input  logic [7:0]  in_door_texture,
  input  logic [21:0] in_start_x,
  input  logic [21:0] in_start_y,
  input  logic signed [16:0] in_dir_x,
  input  logic signed [16:0] in_dir_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_hit_x,
  output logic [5:0]  out_hit_y,
  output logic        out_side,
  output logic [23:0] out_perp_dist,
  output logic [15:0] out_wall_frac,
  output logic [5:0]  out_tex_column,
  output logic [7:0]  out_hit_tile,
  output logic [7:0]  out_texture_index,
  output logic        out_is_door,
  output logic        out_hit_opens_up,
  output logic [8:0]  out_hit_progress,
  output logic        out_escaped
);
  import grd_pkg::*;

  grd_item_t in_item, fq_item, qe_item;
  logic      fq_valid, fq_ready, qe_valid, qe_ready;
  grd_res_t  res;

  assign in_item = '{in_mode, in_cell_x, in_cell_y, in_tile_value, in_door_present,
                     in_door_opens_up, in_door_progress, in_door_texture,
                     in_start_x, in_start_y, in_dir_x, in_dir_y};

  grd_front #(.MAP_SIDE(MAP_SIDE)) u_front (
    .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item));

  grd_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_valid(fq_valid), .wr_ready(fq_ready),
    .wr_data(fq_item), .rd_valid(qe_valid), .rd_ready(qe_ready), .rd_data(qe_item));

  grd_engine #(.MAP_SIDE(MAP_SIDE), .TEX_COLS(TEX_COLS), .MAX_STEPS(MAX_STEPS)) u_eng (
    .clk(clk), .rst_n(rst_n), .q_valid(qe_valid), .q_ready(qe_ready),
    .q_item(qe_item), .res_valid(out_valid), .res_ready(out_ready), .res(res));

  assign out_hit_x         = res.hit_x;
  assign out_hit_y         = res.hit_y;
  assign out_side          = res.side;
  assign out_perp_dist     = res.perp_dist;
  assign out_wall_frac     = res.wall_frac;
  assign out_tex_column    = res.tex_column;
  assign out_hit_tile      = res.hit_tile;
  assign out_texture_index = res.texture_index;
  assign out_is_door       = res.is_door;
  assign out_hit_opens_up  = res.hit_opens_up;
  assign out_hit_progress  = res.hit_progress;
  assign out_escaped       = res.escaped;

  a_esc_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_escaped |-> out_perp_dist == PERP_MAX && !out_is_door)
    else $error("escaped result without saturated distance");

  a_door_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_door |-> !out_hit_opens_up && out_hit_progress == 9'd0)
    else $error("door fields set on a plain wall");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_perp_dist))
    else $error("result dropped while stalled");
endmodule

>>> test/tb_top.sv
// Testbench for the grid ray caster: map writes, directed, back-pressure and random casts.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import grd_pkg::*;

  localparam int SIDE = 64;
  localparam int TCOLS = 64;
  localparam int STEPS_MAX = 128;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic [5:0] in_cell_x = '0, in_cell_y = '0;
  logic [7:0] in_tile_value = '0;
  logic in_door_present = 1'b0, in_door_opens_up = 1'b0;
  logic [8:0] in_door_progress = '0;
  logic [7:0] in_door_texture = '0;
  logic [21:0] in_start_x = '0, in_start_y = '0;
  logic signed [16:0] in_dir_x = '0, in_dir_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] out_hit_x, out_hit_y, out_tex_column;
  logic out_side, out_is_door, out_hit_opens_up, out_escaped;
  logic [23:0] out_perp_dist;
  logic [15:0] out_wall_frac;
  logic [7:0] out_hit_tile, out_texture_index;
  logic [8:0] out_hit_progress;

  grid_ray_dda_wall_hit_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the map kept by the predictor.
  logic [7:0] tile_map [SIDE*SIDE];
  logic [18:0] door_map [SIDE*SIDE];
  grd_res_t hit_queue[$];
  int errors = 0;
  int casts_sent = 0, hits_seen = 0, escapes_seen = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && ((a < 0) != (b < 0))) q--;
    return q;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic grd_res_t trace_ray(logic [21:0] sx, logic [21:0] sy,
                                         logic signed [16:0] dxv, logic signed [16:0] dyv);
    grd_res_t r;
    longint sx0, sy0, dx, dy, mx, my, stx, sty, num, dmain, dother, oth, wall;
    longint unsigned ddx, ddy, sdx, sdy, f, perp, frac, col;
    int side, idx;
    bit hit, takex, outside;
    logic [18:0] d;
    r = '0;
    sx0 = sx; sy0 = sy; dx = dxv; dy = dyv;
    mx = sx0 >>> 16; my = sy0 >>> 16;
    stx = dx < 0 ? -1 : 1; sty = dy < 0 ? -1 : 1;
    ddx = 0; ddy = 0; sdx = 0; sdy = 0; side = 0; hit = 0; idx = 0;
    if (dx != 0) begin
      f = sx0 & 16'hFFFF;
      ddx = (64'd1 << 30) / mag(dx);
      sdx = (dx < 0 ? f : 65536 - f) * ddx;
    end
    if (dy != 0) begin
      f = sy0 & 16'hFFFF;
      ddy = (64'd1 << 30) / mag(dy);
      sdy = (dy < 0 ? f : 65536 - f) * ddy;
    end
    if (dx != 0 || dy != 0) begin
      for (int n = 0; n < STEPS_MAX; n++) begin
        takex = (dy == 0) || (dx != 0 && sdx < sdy);
        if (takex) begin
          sdx += ddx << 16; mx += stx; side = 0;
        end else begin
          sdy += ddy << 16; my += sty; side = 1;
        end
        outside = mx < 0 || my < 0 || mx >= SIDE || my >= SIDE;
        if (outside) break;
        idx = my * SIDE + mx;
        if (tile_map[idx] != 0) begin
          d = door_map[idx];
          if (!(d[0] && d[10:2] >= 256)) begin
            hit = 1;
            break;
          end
        end
      end
    end
    r.side = side[0];
    if (!hit) begin
      r.perp_dist = PERP_MAX;
      r.escaped = 1'b1;
      return r;
    end
    if (side == 0) begin
      num = (stx > 0 ? mx : mx + 1) * 65536 - sx0;
      dmain = dx; dother = dy; oth = sy0;
    end else begin
      num = (sty > 0 ? my : my + 1) * 65536 - sy0;
      dmain = dy; dother = dx; oth = sx0;
    end
    perp = (longint'(mag(num)) << 14) / mag(dmain);
    if (perp > 64'hFFFFFF) perp = 64'hFFFFFF;
    wall = oth + floor_quot(num * dother, dmain);
    frac = wall & 16'hFFFF;
    col = (frac * TCOLS) >> 16;
    if ((side == 0 && dx > 0) || (side == 1 && dy < 0)) col = TCOLS - 1 - col;
    d = door_map[idx];
    r.hit_x = mx[5:0];
    r.hit_y = my[5:0];
    r.perp_dist = perp[23:0];
    r.wall_frac = frac[15:0];
    r.tex_column = col[5:0];
    r.hit_tile = tile_map[idx];
    r.texture_index = d[0] ? d[18:11] : tile_map[idx] - 8'd1;
    r.is_door = d[0];
    r.hit_opens_up = d[0] ? d[1] : 1'b0;
    r.hit_progress = d[0] ? d[10:2] : 9'd0;
    return r;
  endfunction

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 14);
  endfunction

  task automatic send_item(logic mode, logic [5:0] cx, logic [5:0] cy, logic [7:0] tv,
                           logic dp, logic du, logic [8:0] pr, logic [7:0] tx,
                           logic [21:0] sx, logic [21:0] sy,
                           logic [16:0] dxv, logic [16:0] dyv);
    if (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (idle_now()) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_cell_x <= cx; in_cell_y <= cy; in_tile_value <= tv;
    in_door_present <= dp; in_door_opens_up <= du;
    in_door_progress <= pr; in_door_texture <= tx;
    in_start_x <= sx; in_start_y <= sy; in_dir_x <= dxv; in_dir_y <= dyv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Predict at the transfer edge, in order of acceptance.
    if (mode == MODE_WRITE) begin
      tile_map[{cy, cx}] = tv;
      door_map[{cy, cx}] = {tx, pr, du, dp};
    end else begin
      hit_queue.push_back(trace_ray(sx, sy, dxv, dyv));
      casts_sent++;
    end
  endtask

  // Drops valid once a run of items is over.
  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic put_cell(int x, int y, int tv, bit dp = 0, bit du = 0, int pr = 0,
                          int tx = 0);
    send_item(MODE_WRITE, 6'(x), 6'(y), 8'(tv), dp, du, 9'(pr), 8'(tx), 22'($urandom),
              22'($urandom), 17'($urandom), 17'($urandom));
  endtask

  task automatic cast(logic [21:0] sx, logic [21:0] sy, logic [16:0] dxv,
                      logic [16:0] dyv);
    send_item(MODE_CAST, 6'($urandom), 6'($urandom), 8'($urandom), 1'($urandom),
              1'($urandom), 9'($urandom), 8'($urandom), sx, sy, dxv, dyv);
  endtask

  always @(posedge clk) begin
    grd_res_t want;
    if (out_valid && out_ready) begin
      if (hit_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual hit %0d,%0d", $time,
                 out_hit_x, out_hit_y);
        errors++;
      end else begin
        want = hit_queue.pop_front();
        if (out_escaped) escapes_seen++; else hits_seen++;
        if ({out_hit_x, out_hit_y, out_side, out_perp_dist, out_wall_frac, out_tex_column,
             out_hit_tile, out_texture_index, out_is_door, out_hit_opens_up,
             out_hit_progress, out_escaped} !== want) begin
          errors++;
          $display("%0t: mismatch expected x=%0d y=%0d side=%0d perp=%h frac=%h col=%0d",
                   $time, want.hit_x, want.hit_y, want.side, want.perp_dist,
                   want.wall_frac, want.tex_column);
          $display("%0t:   ... tile=%0d tex=%0d door=%0d up=%0d prog=%0d esc=%0d", $time,
                   want.hit_tile, want.texture_index, want.is_door, want.hit_opens_up,
                   want.hit_progress, want.escaped);
          $display("%0t:   actual x=%0d y=%0d side=%0d perp=%h frac=%h col=%0d", $time,
                   out_hit_x, out_hit_y, out_side, out_perp_dist, out_wall_frac,
                   out_tex_column);
          $display("%0t:   ... tile=%0d tex=%0d door=%0d up=%0d prog=%0d esc=%0d", $time,
                   out_hit_tile, out_texture_index, out_is_door, out_hit_opens_up,
                   out_hit_progress, out_escaped);
        end
      end
    end
  end

  // The receiver stalls at random; a long hold-off backs the block up.
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= !idle_now();
  end

  task automatic test_directed();
    // A row of walls, one door of each kind, then casts at edges.
    for (int i = 0; i < 8; i++) put_cell(10 + i, 10, i + 1);
    put_cell(12, 20, 255, 1, 1, 100, 8'hAB);
    put_cell(14, 20, 3, 1, 0, 256, 8'h55);
    put_cell(14, 22, 4);
    put_cell(14, 24, 0, 1, 1, 511, 8'hFF);
    put_cell(63, 63, 7);
    put_cell(63, 64 - 1, 7);
    cast({6'd12, 16'h8000}, {6'd15, 16'h0000}, 17'sd0, -17'sd16384);
    cast({6'd12, 16'hFFFF}, {6'd25, 16'h1234}, 17'sd0, -17'sd65536);
    cast({6'd14, 16'h8000}, {6'd15, 16'h0000}, 17'sd0, 17'sd65535);
    cast({6'd5, 16'h0000}, {6'd10, 16'h8000}, 17'sd65535, 17'sd0);
    cast({6'd12, 16'h0000}, {6'd10, 16'h0000}, 17'sd0, 17'sd0);
    cast({6'd0, 16'h0001}, {6'd0, 16'h0001}, -17'sd1, -17'sd1);
    cast({6'd60, 16'h8000}, {6'd60, 16'h8000}, 17'sd1, 17'sd1);
    cast({6'd63, 16'h0000}, {6'd63, 16'h0000}, 17'sd100, 17'sd0);
    cast(22'h3FFFFF, 22'h3FFFFF, -17'sd65536, -17'sd65535);
    cast({6'd20, 16'h4000}, {6'd0, 16'h0000}, 17'sd3, 17'sd16384);
    stop_sending();
  endtask

  task automatic test_random(int count);
    int x, y;
    for (int n = 0; n < count; n++) begin
      calm = (n >= 150 && n < 250);
      if ($urandom_range(99) < 30) begin
        x = $urandom_range(63); y = $urandom_range(63);
        put_cell(x, y, $urandom_range(3) == 0 ? 0 : $urandom_range(255),
                 1'($urandom_range(1)), 1'($urandom_range(1)),
                 $urandom_range(2) == 0 ? 256 + $urandom_range(255) : $urandom_range(256),
                 $urandom_range(255));
      end else begin
        // Mostly modest directions so rays travel; some at full range.
        if ($urandom_range(3) == 0)
          cast(22'($urandom), 22'($urandom), 17'($urandom), 17'($urandom));
        else
          cast(22'($urandom), 22'($urandom),
               $signed(17'($urandom_range(32768))) - 17'sd16384,
               $signed(17'($urandom_range(32768))) - 17'sd16384);
      end
    end
    calm = 1'b0;
    stop_sending();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int n = 0; n < 8; n++)
          cast(22'($urandom), 22'($urandom), 17'($urandom_range(9000)),
               17'($urandom_range(9000)));
        stop_sending();
      end
    join
  endtask

  initial begin
    for (int i = 0; i < SIDE*SIDE; i++) begin
      tile_map[i] = '0;
      door_map[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(780);
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("Cast %0d rays over a random map with doors: %0d hits, %0d escapes.",
             casts_sent, hits_seen, escapes_seen);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #60ms;
    $display("Timeout waiting for results.");
    $display("Some tests failed");
    $finish;
  end
endmodule
